// ===== rtl/tkvt_pkg.sv =====
// Package for the top-k violation tracker: field widths, limits and shared types.
// Used by every module of the block; depends on nothing.
package tkvt_pkg;

  localparam int ID_W    = 16;  // restraint index on the input
  localparam int VIOL_W  = 24;  // signed Q7.16 violation on the input
  localparam int EID_W   = 17;  // entry index, -1 marks an empty entry
  localparam int VAL_W   = 23;  // positive Q7.16 value
  localparam int SUM_W   = 39;  // Q23.16 frame sum
  localparam int CNT_W   = 17;  // restraint and violation counters
  localparam int RANK_W  = 4;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 152;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (RANK_W + EID_W + 3 * VAL_W + SUM_W + CNT_W);

  localparam int DEF_TOP_COUNT      = 6;
  localparam int DEF_MAX_RESTRAINTS = 65536;

  localparam logic [EID_W-1:0] EMPTY_ID = '1;
  localparam logic [SUM_W-1:0] SUM_MAX  = '1;
  localparam logic [VAL_W-1:0] VAL_MAX  = '1;

  // Result of the shared comparator: value order plus full ranking order.
  typedef struct packed {
    logic val_lt;
    logic val_gt;
    logic ahead;
  } cmp_res_t;

endpackage

// ===== rtl/tkvt_cmp.sv =====
// Shared comparator for the tracker: value compare and ranking order
// (larger value, then earlier stamp, then lower slot). Uses tkvt_pkg.
module tkvt_cmp
  import tkvt_pkg::*;
#(
  parameter int IDX_W = 3
) (
  input  logic [VAL_W-1:0] a_val,
  input  logic [CNT_W-1:0] a_ord,
  input  logic [IDX_W-1:0] a_idx,
  input  logic [VAL_W-1:0] b_val,
  input  logic [CNT_W-1:0] b_ord,
  input  logic [IDX_W-1:0] b_idx,
  output cmp_res_t         res
);

  always_comb begin
    res.val_lt = a_val < b_val;
    res.val_gt = a_val > b_val;
    if (a_val != b_val) begin
      res.ahead = a_val > b_val;
    end else if (a_ord != b_ord) begin
      res.ahead = a_ord < b_ord;
    end else begin
      res.ahead = a_idx < b_idx;
    end
  end

endmodule

// ===== rtl/tkvt_div.sv =====
// Restoring divider for the frame average, one quotient bit per cycle.
// Uses tkvt_pkg for the sum and counter widths.
module tkvt_div
  import tkvt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W:0]    rem;
  logic [SUM_W-1:0]  work;
  logic [CNT_W-1:0]  dvs;
  logic              zero_div;
  logic [CNT_W:0]    trial;
  logic              take;

  assign trial    = {rem[CNT_W-1:0], work[SUM_W-1]};
  assign take     = trial >= {1'b0, dvs};
  assign quotient = zero_div ? '0 : work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        rem      <= '0;
        work     <= dividend;
        dvs      <= divisor;
        zero_div <= divisor == '0;
      end else if (busy) begin
        // shift in the next dividend bit, subtract when it fits
        rem  <= take ? trial - {1'b0, dvs} : trial;
        work <= {work[SUM_W-2:0], take};
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/top_k_violation_tracker.sv =====
// Top level of the top-k violation tracker: sequencer, table, frame statistics.
// Instantiates tkvt_cmp and tkvt_div; uses tkvt_pkg.
//
// Accepts one restraint per request and keeps the TOP_COUNT largest positive
// violations together with the frame sum, maximum and counts. An item with a
// non-positive violation is taken in the idle state alone; for a positive one,
// a single comparator walks the table to find the smallest entry, which is
// replaced if the new value is larger. After that the frame-end item computes
// the average (a start step, 39 bit-serial quotient steps, a step to take the
// result), and the table is sent largest first: each result takes a selection
// scan on the same comparator, then an output state that holds through any
// output stall. Empty entries come out with index -1 and value 0; after the
// last result the table and statistics are cleared. s_tready is low in reset
// and while an item is in progress.
module top_k_violation_tracker
  import tkvt_pkg::*;
#(
  parameter int TOP_COUNT      = DEF_TOP_COUNT,
  parameter int MAX_RESTRAINTS = DEF_MAX_RESTRAINTS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // restraint_id[15:0], violation[39:16]
  input  logic                   s_tlast,  // frame_end
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // rank[3:0], entry_id[20:4], entry_violation[43:21], total_violation[82:44],
  // average_violation[105:83], max_violation[128:106], violated_count[145:129]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast   // last
);

  localparam int IDX_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOP_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RESTRAINTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIN,
    ST_UPD,
    ST_DIVGO,
    ST_DIV,
    ST_SEL,
    ST_OUT
  } state_t;

  state_t state;

  logic [EID_W-1:0] best_id  [TOP_COUNT];
  logic [VAL_W-1:0] best_val [TOP_COUNT];
  logic [CNT_W-1:0] best_ord [TOP_COUNT];
  logic [TOP_COUNT-1:0] emitted;

  logic [SUM_W-1:0] frame_sum;
  logic [VAL_W-1:0] frame_max;
  logic [CNT_W-1:0] positive_count;
  logic [CNT_W-1:0] restraint_count;
  logic [VAL_W-1:0] average;

  logic [ID_W-1:0]  item_id;
  logic [VAL_W-1:0] item_val;
  logic             item_end;

  logic [IDX_W-1:0] scan;
  logic [IDX_W-1:0] out_rank;
  logic             have_cand;
  logic [IDX_W-1:0] cand_idx;
  logic [VAL_W-1:0] cand_val;
  logic [CNT_W-1:0] cand_ord;
  logic [EID_W-1:0] cand_id;

  logic [ID_W-1:0]   in_id;
  logic [VIOL_W-1:0] in_viol;
  logic              in_pos;
  logic [SUM_W:0]    sum_ext;

  logic [VAL_W-1:0] cmp_a_val;
  cmp_res_t         cmp;

  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_q;

  assign in_id   = s_tdata[ID_W-1:0];
  assign in_viol = s_tdata[ID_W +: VIOL_W];
  assign in_pos  = !in_viol[VIOL_W-1] && (in_viol != '0);
  assign sum_ext = {1'b0, frame_sum} + {{(SUM_W + 1 - VAL_W){1'b0}}, in_viol[VAL_W-1:0]};

  assign s_tready  = (state == ST_IDLE) && !rst;
  assign div_start = state == ST_DIVGO;
  assign cmp_a_val = (state == ST_UPD) ? item_val : best_val[scan];

  tkvt_cmp #(
    .IDX_W(IDX_W)
  ) u_cmp (
    .a_val(cmp_a_val),
    .a_ord(best_ord[scan]),
    .a_idx(scan),
    .b_val(cand_val),
    .b_ord(cand_ord),
    .b_idx(cand_idx),
    .res  (cmp)
  );

  tkvt_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(frame_sum),
    .divisor (restraint_count),
    .done    (div_done),
    .quotient(div_q)
  );

  assign m_tdata = {{OUT_PAD_W{1'b0}}, positive_count, frame_max, average, frame_sum,
                    cand_val, cand_id, RANK_W'(out_rank)};
  assign m_tlast = out_rank == LAST_IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      m_tvalid        <= 1'b0;
      emitted         <= '0;
      frame_sum       <= '0;
      frame_max       <= '0;
      positive_count  <= '0;
      restraint_count <= '0;
      scan            <= '0;
      out_rank        <= '0;
      have_cand       <= 1'b0;
      for (int i = 0; i < TOP_COUNT; i++) begin
        best_id[i]  <= EMPTY_ID;
        best_val[i] <= '0;
        best_ord[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            item_id  <= in_id;
            item_val <= in_viol[VAL_W-1:0];
            item_end <= s_tlast;
            if (restraint_count < CNT_MAX) begin
              restraint_count <= restraint_count + 1'b1;
            end
            if (in_pos) begin
              if (positive_count < CNT_MAX) begin
                positive_count <= positive_count + 1'b1;
              end
              frame_sum <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
              if (in_viol[VAL_W-1:0] > frame_max) begin
                frame_max <= in_viol[VAL_W-1:0];
              end
              scan  <= '0;
              state <= ST_MIN;
            end else if (s_tlast) begin
              state <= ST_DIVGO;
            end
          end
        end
        ST_MIN: begin
          // track the smallest entry, first slot wins on ties
          if (scan == '0 || cmp.val_lt) begin
            cand_idx <= scan;
            cand_val <= best_val[scan];
          end
          if (scan == LAST_IDX) begin
            state <= ST_UPD;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        ST_UPD: begin
          if (cmp.val_gt) begin
            best_val[cand_idx] <= item_val;
            best_id[cand_idx]  <= {1'b0, item_id};
            best_ord[cand_idx] <= restraint_count;
          end
          state <= item_end ? ST_DIVGO : ST_IDLE;
        end
        ST_DIVGO: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            average   <= (div_q[SUM_W-1:VAL_W] != '0) ? VAL_MAX : div_q[VAL_W-1:0];
            scan      <= '0;
            have_cand <= 1'b0;
            state     <= ST_SEL;
          end
        end
        ST_SEL: begin
          // pick the highest-ranked entry not yet sent
          if (!emitted[scan] && (!have_cand || cmp.ahead)) begin
            have_cand <= 1'b1;
            cand_idx  <= scan;
            cand_val  <= best_val[scan];
            cand_ord  <= best_ord[scan];
            cand_id   <= best_id[scan];
          end
          if (scan == LAST_IDX) begin
            m_tvalid <= 1'b1;
            state    <= ST_OUT;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            m_tvalid  <= 1'b0;
            scan      <= '0;
            have_cand <= 1'b0;
            if (out_rank == LAST_IDX) begin
              // frame done: drop table and statistics
              out_rank        <= '0;
              emitted         <= '0;
              frame_sum       <= '0;
              frame_max       <= '0;
              positive_count  <= '0;
              restraint_count <= '0;
              for (int i = 0; i < TOP_COUNT; i++) begin
                best_id[i]  <= EMPTY_ID;
                best_val[i] <= '0;
                best_ord[i] <= '0;
              end
              state <= ST_IDLE;
            end else begin
              emitted[cand_idx] <= 1'b1;
              out_rank          <= out_rank + 1'b1;
              state             <= ST_SEL;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_top_k_violation_tracker.sv =====
// Self-checking bench for top_k_violation_tracker: streams restraint frames, predicts the
// ranked table and frame statistics, and checks every emitted entry.
// Depends on tkvt_pkg and the top_k_violation_tracker RTL only.
module tb_top_k_violation_tracker;
  import tkvt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOP_N     = DEF_TOP_COUNT;
  localparam int MAX_RESTR = DEF_MAX_RESTRAINTS;
  localparam int EID_LSB   = RANK_W;
  localparam int VAL_LSB   = EID_LSB + EID_W;
  localparam int SUM_LSB   = VAL_LSB + VAL_W;
  localparam int AVG_LSB   = SUM_LSB + SUM_W;
  localparam int PEAK_LSB  = AVG_LSB + VAL_W;
  localparam int CNT_LSB   = PEAK_LSB + VAL_W;
  localparam int RANDOM_ITEMS = 90;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [EID_W-1:0]  entry_id;
    logic [VAL_W-1:0]  entry_val;
    logic [SUM_W-1:0]  total;
    logic [VAL_W-1:0]  avg;
    logic [VAL_W-1:0]  peak;
    logic [CNT_W-1:0]  count;
    logic              last;
  } table_entry_t;

  // Ranked-table predictor plus the queue of entries still to come out of the block.
  class viol_scoreboard;
    logic [EID_W-1:0] slot_id[TOP_N];
    logic [VAL_W-1:0] slot_val[TOP_N];
    logic [CNT_W-1:0] slot_stamp[TOP_N];
    logic [SUM_W-1:0] sum_acc;
    logic [VAL_W-1:0] peak;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] seen;
    table_entry_t     entries_due[$];
    int               errors;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      foreach (slot_id[i]) begin
        slot_id[i]    = EMPTY_ID;
        slot_val[i]   = '0;
        slot_stamp[i] = '0;
      end
      sum_acc = '0;
      peak    = '0;
      hits    = '0;
      seen    = '0;
    endfunction

    // Larger value first, then earlier stamp, then lower slot.
    function bit ranks_ahead(int j, int i);
      if (slot_val[j] != slot_val[i]) return slot_val[j] > slot_val[i];
      if (slot_stamp[j] != slot_stamp[i]) return slot_stamp[j] < slot_stamp[i];
      return j < i;
    endfunction

    function void note_request(logic [ID_W-1:0] id, logic [VIOL_W-1:0] viol, logic frame_end);
      int           slot;
      int           rank;
      logic [SUM_W:0]   wide_sum;
      logic [SUM_W-1:0] quotient;
      table_entry_t     ranked[TOP_N];
      if (seen < MAX_RESTR) seen++;
      if (!viol[VIOL_W-1] && viol != '0) begin
        if (hits < MAX_RESTR) hits++;
        wide_sum = {1'b0, sum_acc} + viol[VAL_W-1:0];
        sum_acc  = wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
        if (viol[VAL_W-1:0] > peak) peak = viol[VAL_W-1:0];
        // replace the first smallest entry only on a strictly larger value
        slot = 0;
        for (int i = 1; i < TOP_N; i++)
          if (slot_val[i] < slot_val[slot]) slot = i;
        if (viol[VAL_W-1:0] > slot_val[slot]) begin
          slot_val[slot]   = viol[VAL_W-1:0];
          slot_id[slot]    = {1'b0, id};
          slot_stamp[slot] = seen;
        end
      end
      if (!frame_end) return;
      quotient = (seen != '0) ? sum_acc / seen : '0;
      if (quotient > VAL_MAX) quotient = VAL_MAX;
      for (int i = 0; i < TOP_N; i++) begin
        rank = 0;
        for (int j = 0; j < TOP_N; j++)
          if (j != i && ranks_ahead(j, i)) rank++;
        ranked[rank] = '{rank: rank[RANK_W-1:0], entry_id: slot_id[i], entry_val: slot_val[i],
                         total: sum_acc, avg: quotient[VAL_W-1:0], peak: peak, count: hits,
                         last: (rank == TOP_N - 1)};
      end
      foreach (ranked[k]) entries_due.push_back(ranked[k]);
      clear_frame();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic last_flag);
      table_entry_t want;
      if (entries_due.size() == 0) begin
        $error("table entry emitted with none pending: tdata %0h", data);
        errors++;
        return;
      end
      want = entries_due.pop_front();
      compare_field("rank", want.rank, data[RANK_W-1:0]);
      compare_field("entry_id", want.entry_id, data[EID_LSB +: EID_W]);
      compare_field("entry_violation", want.entry_val, data[VAL_LSB +: VAL_W]);
      compare_field("total_violation", want.total, data[SUM_LSB +: SUM_W]);
      compare_field("average_violation", want.avg, data[AVG_LSB +: VAL_W]);
      compare_field("max_violation", want.peak, data[PEAK_LSB +: VAL_W]);
      compare_field("violated_count", want.count, data[CNT_LSB +: CNT_W]);
      compare_field("last", want.last, last_flag);
    endfunction

    function int pending();
      return entries_due.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  viol_scoreboard sb = new();
  bit             no_idle   = 1'b0;
  bit             long_hold = 1'b0;
  int             random_sent = 0;

  top_k_violation_tracker #(
    .TOP_COUNT     (TOP_N),
    .MAX_RESTRAINTS(MAX_RESTR)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Offer one restraint and hold it until the block takes the request.
  task automatic send_restraint(logic [ID_W-1:0] id, logic [VIOL_W-1:0] viol, logic frame_end);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {viol, id};
    s_tlast  <= frame_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(id, viol, frame_end);
  endtask

  // Withdraw the offer and hold until every predicted entry has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [VIOL_W-1:0] draw_violation();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return {1'b1, VAL_W'($urandom)};
      2:       return VIOL_W'($urandom);
      3:       return {1'b0, VAL_MAX};
      4, 5, 6: return VIOL_W'($urandom_range(1, 4));  // crowd of equal values
      default: return VIOL_W'($urandom_range(1, 8388607));
    endcase
  endfunction

  // Receiver: random stall before each entry, plus one long hold-off on request.
  initial begin
    int stall;
    wait (rst === 1'b0);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = draw_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata, m_tlast);
    end
  end

  initial begin
    int frame_len;
    int frame_idx;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lone frame ends: nothing positive, every entry empty
    send_restraint(16'h0000, 24'h000000, 1'b1);
    send_restraint(16'hFFFF, 24'h800000, 1'b1);
    // extremes, a run of equal values, a non-greater value that must be dropped
    send_restraint(16'hFFFF, 24'h7FFFFF, 1'b0);
    send_restraint(16'h0000, 24'h000001, 1'b0);
    send_restraint(16'h0005, 24'hFFFFFF, 1'b0);
    for (int k = 7; k <= 12; k++) send_restraint(k[ID_W-1:0], 24'd100, 1'b0);
    send_restraint(16'h000D, 24'd101, 1'b0);
    send_restraint(16'h000E, 24'd50, 1'b1);
    // fewer positives than table slots: empty entries trail
    send_restraint(16'h1234, 24'h400000, 1'b0);
    send_restraint(16'h00AA, 24'h000000, 1'b0);
    send_restraint(16'hAAAA, 24'h555555, 1'b1);
    wait_drained();

    frame_idx = 0;
    while (random_sent < RANDOM_ITEMS) begin
      no_idle   = ($urandom_range(0, 3) == 0);
      frame_len = $urandom_range(1, 14);
      // stall the output while the sender keeps offering the next frame
      if (frame_idx == 2) long_hold = 1'b1;
      for (int k = 0; k < frame_len; k++) begin
        send_restraint(ID_W'($urandom), draw_violation(), k == frame_len - 1);
        random_sent++;
      end
      if (frame_idx == 5) wait_drained();
      frame_idx++;
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top_k_violation_tracker: clean");
    end else begin
      $display("tb_top_k_violation_tracker: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top_k_violation_tracker: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tkvt_pkg.sv
rtl/tkvt_cmp.sv
rtl/tkvt_div.sv
rtl/top_k_violation_tracker.sv
tb/tb_top_k_violation_tracker.sv
